// ===== rtl/core/tdc_rwd_pkg.sv =====
package tdc_rwd_pkg;

  localparam int WordW  = 32;
  localparam int TypeW  = 5;
  localparam int KindW  = 2;
  localparam int EventW = 22;
  localparam int ChanW  = 7;
  localparam int TimeW  = 21;
  localparam int CountW = 16;

  localparam int TypeLsb  = 27;
  localparam int EventLsb = 5;
  localparam int EdgeBit  = 26;
  localparam int StatBit  = 24;

  typedef logic [TypeW-1:0]  type_code_t;
  typedef logic [KindW-1:0]  kind_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [EventW-1:0] event_t;

  localparam type_code_t TYPE_MEAS   = 5'h00;
  localparam type_code_t TYPE_GHEAD  = 5'h08;
  localparam type_code_t TYPE_GTRAIL = 5'h10;

  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_MEAS    = 2'd1;
  localparam kind_t KIND_TRAILER = 2'd2;

  localparam count_t COUNT_MAX   = 16'hffff;
  localparam count_t COUNT_START = 16'd1;
  localparam count_t MEAS_ADD    = 16'd3;
  localparam count_t TRAIL_ADD   = 16'd1;

  typedef struct packed {
    kind_t              word_kind;
    event_t             event_number;
    logic [ChanW-1:0]   channel;
    logic [TimeW-1:0]   time_value;
    logic               trailing_edge;
    logic               trailer_status;
    count_t             event_word_count;
  } result_t;

  typedef struct packed {
    logic    has_result;
    event_t  event_nxt;
    count_t  count_nxt;
  } dec_ctl_t;

endpackage

// ===== rtl/core/tdc_readout_word_decoder.sv =====
// Readout-word decoder for a multi-hit TDC: takes one 32-bit word per cycle and presents at
// most one result word on the out_ ports per accepted word (input register, then result
// register); global headers, measurements and global trailers produce results, all other
// word types are dropped. Sustained rate is one word per clock, limited only by the result
// register being held while out_stall is high; dropped words keep flowing during such a
// stall unless a result word is in the input register. The layout register mode_1290 is
// written through the cfg port, always ready, and must only change while the decoder is idle.
module tdc_readout_word_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_mode_1290,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tdc_rwd_pkg::WordW-1:0]      in_readout_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tdc_rwd_pkg::KindW-1:0]      out_word_kind,
  output logic [tdc_rwd_pkg::EventW-1:0]     out_event_number,
  output logic [tdc_rwd_pkg::ChanW-1:0]      out_channel,
  output logic [tdc_rwd_pkg::TimeW-1:0]      out_time_value,
  output logic                               out_trailing_edge,
  output logic                               out_trailer_status,
  output logic [tdc_rwd_pkg::CountW-1:0]     out_event_word_count
);

  logic                            mode_r, mode_nxt;
  logic                            s1_valid_r, s1_valid_nxt;
  logic [tdc_rwd_pkg::WordW-1:0]   s1_word_r, s1_word_nxt;
  tdc_rwd_pkg::event_t             event_r, event_nxt;
  tdc_rwd_pkg::count_t             count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  tdc_rwd_pkg::result_t            out_res_r, out_res_nxt;

  tdc_rwd_pkg::dec_ctl_t           dec_ctl;
  tdc_rwd_pkg::result_t            dec_res;
  logic                            in_accept;
  logic                            out_free;
  logic                            s1_go;
  logic                            s1_emit;

  tdc_rwd_decode u_decode (
    .word      (s1_word_r),
    .mode_1290 (mode_r),
    .event_cur (event_r),
    .count_cur (count_r),
    .ctl       (dec_ctl),
    .res       (dec_res)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (out_free || !dec_ctl.has_result);
  assign s1_emit   = s1_go && dec_ctl.has_result;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    mode_nxt      = (cfg_valid && cfg_ready) ? cfg_mode_1290 : mode_r;
    s1_word_nxt   = in_accept ? in_readout_word : s1_word_r;
    s1_valid_nxt  = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    event_nxt     = s1_go ? dec_ctl.event_nxt : event_r;
    count_nxt     = s1_go ? dec_ctl.count_nxt : count_r;
    out_res_nxt   = s1_emit ? dec_res : out_res_r;
    out_valid_nxt = s1_emit ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      event_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      event_r     <= event_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_word_r <= s1_word_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_word_kind        = out_res_r.word_kind;
  assign out_event_number     = out_res_r.event_number;
  assign out_channel          = out_res_r.channel;
  assign out_time_value       = out_res_r.time_value;
  assign out_trailing_edge    = out_res_r.trailing_edge;
  assign out_trailer_status   = out_res_r.trailer_status;
  assign out_event_word_count = out_res_r.event_word_count;

`ifndef ASSERT_OFF
  a_count_sat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == tdc_rwd_pkg::COUNT_MAX) &&
    !(s1_go && (s1_word_r[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW] ==
                tdc_rwd_pkg::TYPE_GHEAD))
    |=> (count_r == tdc_rwd_pkg::COUNT_MAX))
    else $error("saturated word count changed without a header");

  a_trailer_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.word_kind == tdc_rwd_pkg::KIND_TRAILER)
    |-> (out_res_r.event_word_count != '0))
    else $error("trailer reported with zero word count");

  a_non_meas_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.word_kind != tdc_rwd_pkg::KIND_MEAS)
    |-> (out_res_r.channel == '0) && (out_res_r.time_value == '0) &&
        !out_res_r.trailing_edge)
    else $error("measurement fields set on a non-measurement result");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== rtl/core/tdc_rwd_decode.sv =====
module tdc_rwd_decode (
  input  logic [tdc_rwd_pkg::WordW-1:0] word,
  input  logic                          mode_1290,
  input  tdc_rwd_pkg::event_t           event_cur,
  input  tdc_rwd_pkg::count_t           count_cur,
  output tdc_rwd_pkg::dec_ctl_t         ctl,
  output tdc_rwd_pkg::result_t          res
);

  tdc_rwd_pkg::type_code_t         word_type;
  tdc_rwd_pkg::event_t             event_hdr;
  logic [tdc_rwd_pkg::CountW:0]    sum_meas;
  logic [tdc_rwd_pkg::CountW:0]    sum_trail;
  tdc_rwd_pkg::count_t             sat_meas;
  tdc_rwd_pkg::count_t             sat_trail;

  assign word_type = word[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW];
  assign event_hdr = word[tdc_rwd_pkg::EventLsb +: tdc_rwd_pkg::EventW];

  assign sum_meas  = {1'b0, count_cur} + {1'b0, tdc_rwd_pkg::MEAS_ADD};
  assign sum_trail = {1'b0, count_cur} + {1'b0, tdc_rwd_pkg::TRAIL_ADD};
  assign sat_meas  = sum_meas[tdc_rwd_pkg::CountW] ? tdc_rwd_pkg::COUNT_MAX
                                                   : sum_meas[tdc_rwd_pkg::CountW-1:0];
  assign sat_trail = sum_trail[tdc_rwd_pkg::CountW] ? tdc_rwd_pkg::COUNT_MAX
                                                    : sum_trail[tdc_rwd_pkg::CountW-1:0];

  always_comb begin
    res                = '0;
    res.event_number   = event_cur;
    ctl.has_result     = 1'b0;
    ctl.event_nxt      = event_cur;
    ctl.count_nxt      = count_cur;
    unique case (word_type)
      tdc_rwd_pkg::TYPE_GHEAD: begin
        ctl.has_result   = 1'b1;
        ctl.event_nxt    = event_hdr;
        ctl.count_nxt    = tdc_rwd_pkg::COUNT_START;
        res.word_kind    = tdc_rwd_pkg::KIND_HEADER;
        res.event_number = event_hdr;
      end
      tdc_rwd_pkg::TYPE_MEAS: begin
        ctl.has_result    = 1'b1;
        ctl.count_nxt     = sat_meas;
        res.word_kind     = tdc_rwd_pkg::KIND_MEAS;
        res.trailing_edge = word[tdc_rwd_pkg::EdgeBit];
        if (mode_1290) begin
          res.channel    = {2'b00, word[25:21]};
          res.time_value = word[20:0];
        end else begin
          res.channel    = word[25:19];
          res.time_value = {2'b00, word[18:0]};
        end
      end
      tdc_rwd_pkg::TYPE_GTRAIL: begin
        ctl.has_result       = 1'b1;
        ctl.count_nxt        = sat_trail;
        res.word_kind        = tdc_rwd_pkg::KIND_TRAILER;
        res.trailer_status   = word[tdc_rwd_pkg::StatBit];
        res.event_word_count = sat_trail;
      end
      default: begin
        ctl.has_result = 1'b0;
      end
    endcase
  end

endmodule

// ===== test/tb_tdc_readout_word_decoder.sv =====
`timescale 1ns / 100ps

module tb_tdc_readout_word_decoder;

  localparam tdc_rwd_pkg::type_code_t TYPE_THEAD  = 5'h01;
  localparam tdc_rwd_pkg::type_code_t TYPE_TTRAIL = 5'h03;
  localparam tdc_rwd_pkg::type_code_t TYPE_TERR   = 5'h04;
  localparam tdc_rwd_pkg::type_code_t TYPE_FILLER = 5'h18;
  localparam tdc_rwd_pkg::type_code_t TYPE_UNUSED = 5'h1f;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_WORDS   = 155;
  localparam int unsigned PHASES        = 8;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic                                cfg_mode_1290 = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [tdc_rwd_pkg::WordW-1:0]       in_readout_word = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [tdc_rwd_pkg::KindW-1:0]       out_word_kind;
  logic [tdc_rwd_pkg::EventW-1:0]      out_event_number;
  logic [tdc_rwd_pkg::ChanW-1:0]       out_channel;
  logic [tdc_rwd_pkg::TimeW-1:0]       out_time_value;
  logic                                out_trailing_edge;
  logic                                out_trailer_status;
  logic [tdc_rwd_pkg::CountW-1:0]      out_event_word_count;

  logic [tdc_rwd_pkg::WordW-1:0]       word_queue[$];
  tdc_rwd_pkg::result_t                expected_results[$];
  logic                                layout_1290 = 1'b0;
  tdc_rwd_pkg::event_t                 latched_event = '0;
  tdc_rwd_pkg::count_t                 running_count = '0;
  bit                                  word_taken = 1'b0;
  bit                                  idle_en = 1'b1;
  int unsigned                         send_gap = 0;
  int unsigned                         stall_left = 0;
  int unsigned                         fail_count = 0;
  int unsigned                         quiet_cycles = 0;

  tdc_readout_word_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_mode_1290        (cfg_mode_1290),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_readout_word      (in_readout_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_word_kind        (out_word_kind),
    .out_event_number     (out_event_number),
    .out_channel          (out_channel),
    .out_time_value       (out_time_value),
    .out_trailing_edge    (out_trailing_edge),
    .out_trailer_status   (out_trailer_status),
    .out_event_word_count (out_event_word_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [tdc_rwd_pkg::WordW-1:0] make_word(
    tdc_rwd_pkg::type_code_t code, logic [tdc_rwd_pkg::WordW-1:0] body);
    return {code, body[tdc_rwd_pkg::TypeLsb-1:0]};
  endfunction

  function automatic void add_word(logic [tdc_rwd_pkg::WordW-1:0] w);
    word_queue.insert(word_queue.size(), w);
  endfunction

  function automatic tdc_rwd_pkg::count_t add_saturating(tdc_rwd_pkg::count_t a,
                                                         tdc_rwd_pkg::count_t b);
    logic [tdc_rwd_pkg::CountW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, tdc_rwd_pkg::COUNT_MAX}) ? tdc_rwd_pkg::COUNT_MAX
                                                  : sum[tdc_rwd_pkg::CountW-1:0];
  endfunction

  function automatic void decode_word(logic [tdc_rwd_pkg::WordW-1:0] w);
    tdc_rwd_pkg::result_t r;
    r = '0;
    case (w[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW])
      tdc_rwd_pkg::TYPE_GHEAD: begin
        latched_event = w[tdc_rwd_pkg::EventLsb +: tdc_rwd_pkg::EventW];
        running_count = tdc_rwd_pkg::COUNT_START;
        r.word_kind = tdc_rwd_pkg::KIND_HEADER;
      end
      tdc_rwd_pkg::TYPE_MEAS: begin
        r.word_kind = tdc_rwd_pkg::KIND_MEAS;
        if (layout_1290) begin
          r.channel = {2'b00, w[25:21]};
          r.time_value = w[20:0];
        end else begin
          r.channel = w[25:19];
          r.time_value = {2'b00, w[18:0]};
        end
        r.trailing_edge = w[tdc_rwd_pkg::EdgeBit];
        running_count = add_saturating(running_count, tdc_rwd_pkg::MEAS_ADD);
      end
      tdc_rwd_pkg::TYPE_GTRAIL: begin
        running_count = add_saturating(running_count, tdc_rwd_pkg::TRAIL_ADD);
        r.word_kind = tdc_rwd_pkg::KIND_TRAILER;
        r.trailer_status = w[tdc_rwd_pkg::StatBit];
        r.event_word_count = running_count;
      end
      default: return;
    endcase
    r.event_number = latched_event;
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_en || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    tdc_rwd_pkg::result_t exp_r;
    word_taken = in_valid && !in_stall;
    if (!rst_n) begin
      layout_1290 = 1'b0;
      latched_event = '0;
      running_count = '0;
    end else begin
      if (cfg_valid && cfg_ready) layout_1290 = cfg_mode_1290;
      if (word_taken) decode_word(in_readout_word);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word, kind %0d", out_word_kind);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("word_kind", 32'(exp_r.word_kind), 32'(out_word_kind));
          check_field("event_number", 32'(exp_r.event_number), 32'(out_event_number));
          check_field("channel", 32'(exp_r.channel), 32'(out_channel));
          check_field("time_value", 32'(exp_r.time_value), 32'(out_time_value));
          check_field("trailing_edge", 32'(exp_r.trailing_edge), 32'(out_trailing_edge));
          check_field("trailer_status", 32'(exp_r.trailer_status),
                      32'(out_trailer_status));
          check_field("event_word_count", 32'(exp_r.event_word_count),
                      32'(out_event_word_count));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (word_queue.size() > 0) begin
        in_readout_word <= word_queue.pop_front();
        in_valid <= 1'b1;
        send_gap = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(99) < 30) stall_left = draw_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic wait_idle();
    while (word_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_mode_1290 <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned queue_random_burst();
    int unsigned n_meas;
    int unsigned pick;
    int unsigned produced;
    logic [tdc_rwd_pkg::WordW-1:0] rnd;
    produced = 0;
    pick = $urandom_range(99);
    if (pick < 80) begin
      add_word(make_word(tdc_rwd_pkg::TYPE_GHEAD, $urandom));
      if ($urandom_range(1)) add_word(make_word(TYPE_THEAD, $urandom));
      n_meas = $urandom_range(8);
      repeat (n_meas) begin
        if ($urandom_range(9) == 0) add_word(make_word(TYPE_FILLER, $urandom));
        if ($urandom_range(19) == 0) add_word(make_word(TYPE_TERR, $urandom));
        add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, $urandom));
      end
      if ($urandom_range(1)) add_word(make_word(TYPE_TTRAIL, $urandom));
      add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, $urandom));
      produced = n_meas + 2;
    end else if (pick < 90) begin
      n_meas = $urandom_range(3);
      repeat (n_meas) add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, $urandom));
      add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, $urandom));
      produced = n_meas + 1;
    end else begin
      rnd = $urandom;
      add_word(rnd);
      if (rnd[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW] == tdc_rwd_pkg::TYPE_MEAS ||
          rnd[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW] == tdc_rwd_pkg::TYPE_GHEAD ||
          rnd[tdc_rwd_pkg::TypeLsb +: tdc_rwd_pkg::TypeW] == tdc_rwd_pkg::TYPE_GTRAIL)
        produced = 1;
    end
    return produced;
  endfunction

  initial begin
    int unsigned produced;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_GHEAD, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h0000_0000));
    add_word(make_word(TYPE_FILLER, 32'h07ff_ffff));
    add_word(make_word(TYPE_THEAD, 32'h0000_0000));
    add_word(make_word(TYPE_TTRAIL, 32'h07ff_ffff));
    add_word(make_word(TYPE_UNUSED, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, 32'h0000_0000));
    add_word(make_word(tdc_rwd_pkg::TYPE_GHEAD, 32'h0000_0000));
    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h0400_0000));
    wait_idle();
    write_mode(1'b1);

    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h001f_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_MEAS, 32'h03e0_0000));
    add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, 32'h0100_0000));
    add_word(make_word(tdc_rwd_pkg::TYPE_GHEAD, 32'h07ff_ffe0));
    add_word(make_word(TYPE_TERR, 32'h07ff_ffff));
    add_word(make_word(tdc_rwd_pkg::TYPE_GTRAIL, 32'h06ff_ffff));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_mode(p[0] ? 1'b0 : 1'b1);
      idle_en = (p % 4 != 3);
      produced = 0;
      while (produced < PHASE_WORDS) produced += queue_random_burst();
      wait_idle();
    end

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tdc_rwd_pkg.sv
rtl/core/tdc_rwd_decode.sv
rtl/core/tdc_readout_word_decoder.sv
test/tb_tdc_readout_word_decoder.sv
